/* rtl/three_phase_harmonic_synth_defines.svh */
`ifndef THREE_PHASE_HARMONIC_SYNTH_DEFINES_SVH
`define THREE_PHASE_HARMONIC_SYNTH_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TPHS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define TPHS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tphs_pkg.sv */
package tphs_pkg;

    localparam int NUM_HARMONICS_DEF  = 15;
    localparam int COEF_WIDTH_DEF     = 16;
    localparam int PHASE_BITS_DEF     = 16;
    localparam int SINE_ADDR_BITS_DEF = 10;

    localparam int HARM_W     = 4;
    localparam int SEQ_W      = 2;
    localparam int IN_COEF_W  = 16;
    localparam int IN_PHASE_W = 16;
    localparam int OUT_W      = 24;
    localparam int MULT_W     = 17;
    localparam int SAMPLE_W   = 15;
    localparam int NUM_SEQ    = 3;
    localparam int FRAC_BITS  = 15;
    localparam int OUT_MAX    = 8388607;
    localparam int OUT_MIN    = -8388608;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [SEQ_W-1:0] SEQ_POS  = 2'd0;
    localparam logic [SEQ_W-1:0] SEQ_NEG  = 2'd1;
    localparam logic [SEQ_W-1:0] SEQ_ZERO = 2'd2;
    localparam logic [SEQ_W-1:0] SEQ_NONE = 2'd3;

    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    // Inverse transform weights in Q15
    localparam logic signed [MULT_W-1:0] K_ONE    = 17'sd32768;
    localparam logic signed [MULT_W-1:0] K_NHALF  = -17'sd16384;
    localparam logic signed [MULT_W-1:0] K_SQRT3  = 17'sd28378;
    localparam logic signed [MULT_W-1:0] K_NSQRT3 = -17'sd28378;
    localparam logic signed [MULT_W-1:0] K_NONE   = 17'sd0;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                         command;
        logic [HARM_W-1:0]            harmonic;
        logic [SEQ_W-1:0]             sequence_req;
        logic signed [IN_COEF_W-1:0]  coef_real;
        logic signed [IN_COEF_W-1:0]  coef_imag;
        logic [IN_PHASE_W-1:0]        phase;
    } t_req;

    typedef struct packed {
        logic signed [OUT_W-1:0] phase_a;
        logic signed [OUT_W-1:0] phase_b;
        logic signed [OUT_W-1:0] phase_c;
    } t_res;

    typedef struct packed {
        logic       clear;
        logic       valid;
        logic [1:0] sel;
    } t_mac_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Quarter-wave sine sample for step r of a quarter turn split in 2^qshift steps
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input longint unsigned r,
                                                        input int qshift);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned s;
        z  = (r * HALF_PI_Q30) >> qshift;
        z2 = (z * z) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((z2 * t) >> 30) / 64'd6;
        s  = (z * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    // Weight of the DC column: k selects the imaginary part
    function automatic logic signed [MULT_W-1:0] dc_mult(input logic [SEQ_W-1:0] seq,
                                                         input logic [1:0] ph,
                                                         input logic k);
        if (!k) begin
            if (seq == SEQ_ZERO || ph == PH_A) begin
                return K_ONE;
            end
            return K_NHALF;
        end
        if (seq == SEQ_ZERO || ph == PH_A) begin
            return K_NONE;
        end
        if ((seq == SEQ_POS) == (ph == PH_B)) begin
            return K_SQRT3;
        end
        return K_NSQRT3;
    endfunction

endpackage

/* rtl/tphs_table.sv */
module tphs_table #(
    parameter int NUM_HARMONICS = tphs_pkg::NUM_HARMONICS_DEF,
    parameter int COEF_WIDTH    = tphs_pkg::COEF_WIDTH_DEF,
    localparam int ROWS         = (NUM_HARMONICS + 1) * tphs_pkg::NUM_SEQ,
    localparam int RW           = $clog2(ROWS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr_en,
    input  logic [tphs_pkg::HARM_W-1:0]            i_wr_harm,
    input  logic [tphs_pkg::SEQ_W-1:0]             i_wr_seq,
    input  logic signed [tphs_pkg::IN_COEF_W-1:0]  i_wr_re,
    input  logic signed [tphs_pkg::IN_COEF_W-1:0]  i_wr_im,
    input  logic [RW-1:0]                          i_rd_row,
    output logic signed [COEF_WIDTH-1:0]           o_re,
    output logic signed [COEF_WIDTH-1:0]           o_im
);

    localparam int CHI = (1 << (COEF_WIDTH - 1)) - 1;
    localparam int CLO = -CHI - 1;

    logic [2*COEF_WIDTH-1:0] r_mem [ROWS];
    logic [ROWS-1:0]         r_vld;
    logic [2*COEF_WIDTH-1:0] r_rd_data;
    logic                    r_rd_vld;
    logic [6:0]              w_wr_full;
    logic [RW-1:0]           w_wr_row;
    logic                    w_wr_ok;

    function automatic logic signed [COEF_WIDTH-1:0] clamp_coef(
        input logic signed [tphs_pkg::IN_COEF_W-1:0] v);
        if (int'(v) > CHI) begin
            return COEF_WIDTH'(CHI);
        end
        if (int'(v) < CLO) begin
            return COEF_WIDTH'(CLO);
        end
        return COEF_WIDTH'(v);
    endfunction

    assign w_wr_full = 7'({i_wr_harm, 1'b0}) + 7'(i_wr_harm) + 7'(i_wr_seq);
    assign w_wr_row  = RW'(w_wr_full);
    assign w_wr_ok   = i_wr_en && (i_wr_seq != tphs_pkg::SEQ_NONE)
                       && (int'(i_wr_harm) <= NUM_HARMONICS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr_ok) begin
            r_vld[w_wr_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[w_wr_row] <= {clamp_coef(i_wr_re), clamp_coef(i_wr_im)};
        end
        r_rd_data <= r_mem[i_rd_row];
        r_rd_vld  <= r_vld[i_rd_row];
    end

    // A row never written reads as zero
    assign o_re = r_rd_vld ? $signed(r_rd_data[2*COEF_WIDTH-1:COEF_WIDTH]) : '0;
    assign o_im = r_rd_vld ? $signed(r_rd_data[COEF_WIDTH-1:0]) : '0;

endmodule

/* rtl/tphs_sine_rom.sv */
module tphs_sine_rom #(
    parameter int SINE_ADDR_BITS = tphs_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [SINE_ADDR_BITS-1:0]           i_addr,
    output logic signed [tphs_pkg::MULT_W-1:0]  o_sample
);

    localparam int QN = 1 << (SINE_ADDR_BITS - 2);
    localparam int IW = SINE_ADDR_BITS - 1;

    logic [tphs_pkg::SAMPLE_W-1:0]       w_qtab [QN+1];
    logic [IW-1:0]                       w_r;
    logic [IW-1:0]                       w_idx;
    logic [tphs_pkg::SAMPLE_W-1:0]       r_mag;
    logic                                r_neg;
    logic signed [tphs_pkg::MULT_W-1:0]  w_pos;

    for (genvar g = 0; g <= QN; g++) begin : g_qtab
        assign w_qtab[g] = tphs_pkg::quarter_sine(64'(g), SINE_ADDR_BITS - 2);
    end

    // Mirror the second and fourth quarters
    assign w_r   = IW'(i_addr[SINE_ADDR_BITS-3:0]);
    assign w_idx = i_addr[SINE_ADDR_BITS-2] ? IW'(QN) - w_r : w_r;

    always_ff @(posedge i_clk) begin
        r_mag <= w_qtab[w_idx];
        r_neg <= i_addr[SINE_ADDR_BITS-1];
    end

    assign w_pos    = $signed(tphs_pkg::MULT_W'(r_mag));
    assign o_sample = r_neg ? -w_pos : w_pos;

endmodule

/* rtl/tphs_mac.sv */
module tphs_mac #(
    parameter int NUM_HARMONICS = tphs_pkg::NUM_HARMONICS_DEF,
    parameter int COEF_WIDTH    = tphs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tphs_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [COEF_WIDTH-1:0]        i_coef,
    input  logic signed [tphs_pkg::MULT_W-1:0]  i_mult,
    output logic                                o_busy,
    output tphs_pkg::t_res                      o_res
);

    localparam int PROD_W = COEF_WIDTH + tphs_pkg::MULT_W;
    localparam int ACC_W  = PROD_W + $clog2((NUM_HARMONICS + 1) * 6) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(tphs_pkg::OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(tphs_pkg::OUT_MIN);

    logic                                r_in_v;
    logic                                r_prod_v;
    logic [1:0]                          r_in_sel;
    logic [1:0]                          r_prod_sel;
    logic signed [COEF_WIDTH-1:0]        r_coef;
    logic signed [tphs_pkg::MULT_W-1:0]  r_mult;
    logic signed [PROD_W-1:0]            r_prod;
    logic signed [ACC_W-1:0]             r_acc   [3];
    logic signed [ACC_W-1:0]             w_shift [3];
    logic signed [tphs_pkg::OUT_W-1:0]   w_sat   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_in_v   <= i_ctl.valid;
            r_prod_v <= r_in_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_sel   <= i_ctl.sel;
        r_coef     <= i_coef;
        r_mult     <= i_mult;
        r_prod     <= r_coef * r_mult;
        r_prod_sel <= r_in_sel;
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (i_ctl.clear) begin
                r_acc[l] <= '0;
            end else if (r_prod_v && r_prod_sel == 2'(l)) begin
                r_acc[l] <= r_acc[l] + ACC_W'(r_prod);
            end
        end
    end

    // Floor shift out the Q.15 fraction, then saturate to the output range
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_shift[l] = r_acc[l] >>> tphs_pkg::FRAC_BITS;
            if (w_shift[l] > SAT_HI) begin
                w_sat[l] = tphs_pkg::OUT_W'(tphs_pkg::OUT_MAX);
            end else if (w_shift[l] < SAT_LO) begin
                w_sat[l] = tphs_pkg::OUT_W'(tphs_pkg::OUT_MIN);
            end else begin
                w_sat[l] = tphs_pkg::OUT_W'(w_shift[l]);
            end
        end
    end

    assign o_busy        = r_in_v | r_prod_v;
    assign o_res.phase_a = w_sat[0];
    assign o_res.phase_b = w_sat[1];
    assign o_res.phase_c = w_sat[2];

endmodule

/* rtl/three_phase_harmonic_synth.sv */
// Channel  Dir  Handshake                   Payload
// request  in   i_req_valid / o_req_stall   tphs_pkg::t_req
// result   out  o_res_valid / i_res_stall   tphs_pkg::t_res
//
// A write transaction gives no result.
// An evaluation steps one product a cycle through the single multiply-accumulate
// unit, 18*(NUM_HARMONICS+1) steps, and presents its result after the pipeline
// drains (states S_RUN, S_DRAIN, S_DONE).
// Synchronous active-low reset clears control and the per-row valid bits of the
// phasor table; there is no clearing pass.
// o_req_stall is high while an evaluation runs; a held result does not block writes,
// and a finished evaluation waits until the previous result is taken.
`include "three_phase_harmonic_synth_defines.svh"

module three_phase_harmonic_synth #(
    parameter int NUM_HARMONICS  = tphs_pkg::NUM_HARMONICS_DEF,
    parameter int COEF_WIDTH     = tphs_pkg::COEF_WIDTH_DEF,
    parameter int PHASE_BITS     = tphs_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = tphs_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  tphs_pkg::t_req i_req,
    output logic           o_res_valid,
    input  logic           i_res_stall,
    output tphs_pkg::t_res o_res
);

    localparam int HW   = $clog2(NUM_HARMONICS + 1);
    localparam int ROWS = (NUM_HARMONICS + 1) * tphs_pkg::NUM_SEQ;
    localparam int RW   = $clog2(ROWS);
    localparam logic [HW-1:0] H_LAST = HW'(NUM_HARMONICS);
    localparam logic [PHASE_BITS-1:0] ANG_THIRD =
        PHASE_BITS'((64'd1 << PHASE_BITS) / 64'd3);
    localparam logic [PHASE_BITS-1:0] ANG_NTHIRD =
        PHASE_BITS'((64'd1 << PHASE_BITS) - (64'd1 << PHASE_BITS) / 64'd3);
    localparam logic [PHASE_BITS-1:0] ANG_QUARTER = PHASE_BITS'(64'd1 << (PHASE_BITS - 2));

    tphs_pkg::t_state                    r_state;
    tphs_pkg::t_state                    n_state;
    logic [HW-1:0]                       r_h;
    logic [HW-1:0]                       n_h;
    logic [tphs_pkg::SEQ_W-1:0]          r_s;
    logic [tphs_pkg::SEQ_W-1:0]          n_s;
    logic [1:0]                          r_p;
    logic [1:0]                          n_p;
    logic                                r_k;
    logic                                n_k;
    logic [PHASE_BITS-1:0]               r_th;
    logic [PHASE_BITS-1:0]               n_th;
    logic [PHASE_BITS-1:0]               r_base;
    logic [PHASE_BITS-1:0]               w_base;
    logic                                w_issue;
    logic                                w_load;
    logic                                w_eval_take;
    logic                                w_wr_en;
    logic [PHASE_BITS-1:0]               w_off;
    logic [PHASE_BITS-1:0]               w_ang;
    logic [SINE_ADDR_BITS-1:0]           w_addr;
    logic [HW+1:0]                       w_row_full;
    logic                                r1_v;
    logic [1:0]                          r1_sel;
    logic                                r1_k;
    logic                                r1_dc;
    logic [tphs_pkg::SEQ_W-1:0]          r1_seq;
    logic signed [COEF_WIDTH-1:0]        w_re;
    logic signed [COEF_WIDTH-1:0]        w_im;
    logic signed [tphs_pkg::MULT_W-1:0]  w_sample;
    logic signed [tphs_pkg::MULT_W-1:0]  w_mult;
    logic signed [COEF_WIDTH-1:0]        w_coef;
    tphs_pkg::t_mac_ctl                  w_mac_ctl;
    logic                                w_mac_busy;
    tphs_pkg::t_res                      w_mac_res;
    logic                                r_res_valid;
    tphs_pkg::t_res                      r_res;

    // Scale the incoming angle to PHASE_BITS
    if (PHASE_BITS >= tphs_pkg::IN_PHASE_W) begin : g_base_up
        assign w_base = PHASE_BITS'(i_req.phase) << (PHASE_BITS - tphs_pkg::IN_PHASE_W);
    end else begin : g_base_dn
        assign w_base = PHASE_BITS'(i_req.phase >> (tphs_pkg::IN_PHASE_W - PHASE_BITS));
    end

    assign o_req_stall = (r_state != tphs_pkg::S_IDLE);
    assign w_wr_en     = i_req_valid && !o_req_stall && (i_req.command == tphs_pkg::CMD_WRITE);
    assign w_eval_take = i_req_valid && !o_req_stall && (i_req.command == tphs_pkg::CMD_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tphs_pkg::S_IDLE;
            r_h     <= '0;
            r_s     <= tphs_pkg::SEQ_POS;
            r_p     <= tphs_pkg::PH_A;
            r_k     <= 1'b0;
            r_th    <= '0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_s     <= n_s;
            r_p     <= n_p;
            r_k     <= n_k;
            r_th    <= n_th;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval_take) begin
            r_base <= w_base;
        end
    end

    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_s     = r_s;
        n_p     = r_p;
        n_k     = r_k;
        n_th    = r_th;
        w_issue = 1'b0;
        w_load  = 1'b0;
        case (r_state)
            tphs_pkg::S_IDLE: begin
                if (w_eval_take) begin
                    n_state = tphs_pkg::S_RUN;
                    n_h     = '0;
                    n_s     = tphs_pkg::SEQ_POS;
                    n_p     = tphs_pkg::PH_A;
                    n_k     = 1'b0;
                    n_th    = '0;
                end
            end
            tphs_pkg::S_RUN: begin
                w_issue = 1'b1;
                n_k     = ~r_k;
                if (r_k) begin
                    if (r_p == tphs_pkg::PH_C) begin
                        n_p = tphs_pkg::PH_A;
                        if (r_s == tphs_pkg::SEQ_ZERO) begin
                            n_s = tphs_pkg::SEQ_POS;
                            if (r_h == H_LAST) begin
                                n_state = tphs_pkg::S_DRAIN;
                            end else begin
                                n_h  = r_h + HW'(1);
                                n_th = r_th + r_base;
                            end
                        end else begin
                            n_s = r_s + 2'd1;
                        end
                    end else begin
                        n_p = r_p + 2'd1;
                    end
                end
            end
            tphs_pkg::S_DRAIN: begin
                if (!r1_v && !w_mac_busy) begin
                    n_state = tphs_pkg::S_DONE;
                end
            end
            tphs_pkg::S_DONE: begin
                if (!r_res_valid || !i_res_stall) begin
                    w_load  = 1'b1;
                    n_state = tphs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tphs_pkg::S_IDLE;
            end
        endcase
    end

    // Angle of the current step: harmonic angle, phase offset, cosine quarter turn
    always_comb begin
        w_off = '0;
        if (r_p == tphs_pkg::PH_B) begin
            w_off = (r_s == tphs_pkg::SEQ_POS) ? ANG_NTHIRD :
                    (r_s == tphs_pkg::SEQ_NEG) ? ANG_THIRD : '0;
        end else if (r_p == tphs_pkg::PH_C) begin
            w_off = (r_s == tphs_pkg::SEQ_POS) ? ANG_THIRD :
                    (r_s == tphs_pkg::SEQ_NEG) ? ANG_NTHIRD : '0;
        end
    end

    assign w_ang = r_th + w_off + (r_k ? ANG_QUARTER : '0);

    if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_dn
        assign w_addr = SINE_ADDR_BITS'(w_ang >> (PHASE_BITS - SINE_ADDR_BITS));
    end else begin : g_addr_up
        assign w_addr = SINE_ADDR_BITS'(w_ang) << (SINE_ADDR_BITS - PHASE_BITS);
    end

    assign w_row_full = (HW + 2)'({r_h, 1'b0}) + (HW + 2)'(r_h) + (HW + 2)'(r_s);

    tphs_table #(
        .NUM_HARMONICS (NUM_HARMONICS),
        .COEF_WIDTH    (COEF_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_harm (i_req.harmonic),
        .i_wr_seq  (i_req.sequence_req),
        .i_wr_re   (i_req.coef_real),
        .i_wr_im   (i_req.coef_imag),
        .i_rd_row  (RW'(w_row_full)),
        .o_re      (w_re),
        .o_im      (w_im)
    );

    tphs_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .i_clk    (i_clk),
        .i_addr   (w_addr),
        .o_sample (w_sample)
    );

    // Step tags travel alongside the table and ROM reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_sel <= r_p;
        r1_k   <= r_k;
        r1_dc  <= (r_h == '0);
        r1_seq <= r_s;
    end

    assign w_mult = r1_dc ? tphs_pkg::dc_mult(r1_seq, r1_sel, r1_k) : w_sample;
    assign w_coef = r1_k ? w_im : w_re;

    assign w_mac_ctl.clear = w_eval_take;
    assign w_mac_ctl.valid = r1_v;
    assign w_mac_ctl.sel   = r1_sel;

    tphs_mac #(
        .NUM_HARMONICS (NUM_HARMONICS),
        .COEF_WIDTH    (COEF_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_mult  (w_mult),
        .o_busy  (w_mac_busy),
        .o_res   (w_mac_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_load) begin
            r_res_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= w_mac_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `TPHS_ASSERT_IMP(a_res_after_done, $rose(o_res_valid), $past(r_state) == tphs_pkg::S_DONE, "result raised outside done")
    `TPHS_ASSERT_IMP(a_drained_at_done, r_state == tphs_pkg::S_DONE, !r1_v && !w_mac_busy, "pipeline busy at done")
    `TPHS_ASSERT_NXT(a_write_no_result, w_wr_en && !o_res_valid, !o_res_valid, "write produced a result")
    `TPHS_ASSERT_NXT(a_eval_starts_clean, w_eval_take, r_h == '0 && r_th == '0 && !r_k, "evaluation did not restart counters")

endmodule

/* tb/sv/tb_three_phase_harmonic_synth.sv */
`timescale 1ns / 100ps

class phase_scoreboard;

    localparam int COLS        = tphs_pkg::NUM_HARMONICS_DEF + 1;
    localparam int ROM_DEPTH   = 1 << tphs_pkg::SINE_ADDR_BITS_DEF;
    localparam int QUARTER_ROM = 1 << (tphs_pkg::SINE_ADDR_BITS_DEF - 2);
    localparam int ADDR_SHIFT  = tphs_pkg::PHASE_BITS_DEF - tphs_pkg::SINE_ADDR_BITS_DEF;
    localparam int ANG_MASK    = (1 << tphs_pkg::PHASE_BITS_DEF) - 1;
    localparam int ANG_FULL    = 1 << tphs_pkg::PHASE_BITS_DEF;
    localparam int ANG_THIRD   = ANG_FULL / 3;
    localparam int ANG_QUARTER = ANG_FULL / 4;
    localparam int SQRT3_Q15   = 28378;
    localparam int HALF_Q15    = 16384;
    localparam int ONE_Q15     = 32768;

    int              coef_re[COLS][tphs_pkg::NUM_SEQ];
    int              coef_im[COLS][tphs_pkg::NUM_SEQ];
    int              sine_rom[ROM_DEPTH];
    tphs_pkg::t_res  expected_phases[$];
    int              mismatches;

    function new();
        int q;
        int r;
        int v;
        mismatches = 0;
        for (int h = 0; h < COLS; h++) begin
            for (int s = 0; s < tphs_pkg::NUM_SEQ; s++) begin
                coef_re[h][s] = 0;
                coef_im[h][s] = 0;
            end
        end
        for (int k = 0; k < ROM_DEPTH; k++) begin
            q = k / QUARTER_ROM;
            r = k % QUARTER_ROM;
            v = (q & 1) ? quarter_wave(QUARTER_ROM - r) : quarter_wave(r);
            sine_rom[k] = (q & 2) ? -v : v;
        end
    endfunction

    // Taylor series of sin on a quarter turn, in unsigned Q30, rounded to Q15
    function int quarter_wave(int unsigned step);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned t;
        longint unsigned acc;
        int unsigned     divs[5];
        divs = '{110, 72, 42, 20, 6};
        z  = (longint'(step) * 64'd1686629713) / QUARTER_ROM;
        z2 = (z * z) >> 30;
        t  = 64'd1 << 30;
        foreach (divs[i]) begin
            t = (64'd1 << 30) - ((z2 * t) >> 30) / divs[i];
        end
        acc = (z * t) >> 30;
        acc = (acc + 64'd16384) >> 15;
        if (acc > 64'd32767) begin
            acc = 64'd32767;
        end
        return int'(acc);
    endfunction

    function longint sine_mix(int re, int im, int unsigned ang);
        int unsigned ang_cos;
        ang_cos = (ang + ANG_QUARTER) & ANG_MASK;
        return longint'(re) * sine_rom[(ang & ANG_MASK) >> ADDR_SHIFT]
             + longint'(im) * sine_rom[ang_cos >> ADDR_SHIFT];
    endfunction

    function logic [tphs_pkg::OUT_W-1:0] saturate_out(longint acc);
        longint v;
        v = acc >>> tphs_pkg::FRAC_BITS;
        if (v > tphs_pkg::OUT_MAX) begin
            v = tphs_pkg::OUT_MAX;
        end
        if (v < tphs_pkg::OUT_MIN) begin
            v = tphs_pkg::OUT_MIN;
        end
        return v[tphs_pkg::OUT_W-1:0];
    endfunction

    function tphs_pkg::t_res predict_phases(logic [tphs_pkg::IN_PHASE_W-1:0] angle);
        longint          acc[3];
        longint          real_sum;
        longint          imag_diff;
        int unsigned     th;
        int unsigned     off_b;
        int unsigned     off_c;
        tphs_pkg::t_res  res;
        real_sum  = longint'(coef_re[0][tphs_pkg::SEQ_POS]) + coef_re[0][tphs_pkg::SEQ_NEG];
        imag_diff = longint'(coef_im[0][tphs_pkg::SEQ_POS]) - coef_im[0][tphs_pkg::SEQ_NEG];
        acc[0] = (real_sum + coef_re[0][tphs_pkg::SEQ_ZERO]) * ONE_Q15;
        acc[1] = -real_sum * HALF_Q15 + imag_diff * SQRT3_Q15
                 + longint'(coef_re[0][tphs_pkg::SEQ_ZERO]) * ONE_Q15;
        acc[2] = -real_sum * HALF_Q15 - imag_diff * SQRT3_Q15
                 + longint'(coef_re[0][tphs_pkg::SEQ_ZERO]) * ONE_Q15;
        for (int h = 1; h < COLS; h++) begin
            th = (h * int'(angle)) & ANG_MASK;
            for (int s = 0; s < tphs_pkg::NUM_SEQ; s++) begin
                case (s)
                    tphs_pkg::SEQ_POS: begin
                        off_b = ANG_FULL - ANG_THIRD;
                        off_c = ANG_THIRD;
                    end
                    tphs_pkg::SEQ_NEG: begin
                        off_b = ANG_THIRD;
                        off_c = ANG_FULL - ANG_THIRD;
                    end
                    default: begin
                        off_b = 0;
                        off_c = 0;
                    end
                endcase
                acc[0] += sine_mix(coef_re[h][s], coef_im[h][s], th);
                acc[1] += sine_mix(coef_re[h][s], coef_im[h][s], (th + off_b) & ANG_MASK);
                acc[2] += sine_mix(coef_re[h][s], coef_im[h][s], (th + off_c) & ANG_MASK);
            end
        end
        res.phase_a = saturate_out(acc[0]);
        res.phase_b = saturate_out(acc[1]);
        res.phase_c = saturate_out(acc[2]);
        return res;
    endfunction

    function int clamp_coef(logic signed [tphs_pkg::IN_COEF_W-1:0] v);
        int hi;
        int lo;
        hi = (1 << (tphs_pkg::COEF_WIDTH_DEF - 1)) - 1;
        lo = -hi - 1;
        if (int'(v) > hi) begin
            return hi;
        end
        if (int'(v) < lo) begin
            return lo;
        end
        return int'(v);
    endfunction

    function void note_request(tphs_pkg::t_req req);
        if (req.command == tphs_pkg::CMD_EVAL) begin
            expected_phases.push_back(predict_phases(req.phase));
        end else if (req.sequence_req != tphs_pkg::SEQ_NONE
                     && req.harmonic <= tphs_pkg::NUM_HARMONICS_DEF) begin
            coef_re[req.harmonic][req.sequence_req] = clamp_coef(req.coef_real);
            coef_im[req.harmonic][req.sequence_req] = clamp_coef(req.coef_imag);
        end
    endfunction

    task report(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(tphs_pkg::t_res got);
        tphs_pkg::t_res want;
        if (expected_phases.size() == 0) begin
            report($sformatf("unexpected result a=%0d b=%0d c=%0d",
                             got.phase_a, got.phase_b, got.phase_c));
            return;
        end
        want = expected_phases.pop_front();
        if (got.phase_a !== want.phase_a) begin
            report($sformatf("phase_a got %0d expected %0d", got.phase_a, want.phase_a));
        end
        if (got.phase_b !== want.phase_b) begin
            report($sformatf("phase_b got %0d expected %0d", got.phase_b, want.phase_b));
        end
        if (got.phase_c !== want.phase_c) begin
            report($sformatf("phase_c got %0d expected %0d", got.phase_c, want.phase_c));
        end
    endtask

    task check_drained();
        if (expected_phases.size() != 0) begin
            report($sformatf("%0d results never arrived", expected_phases.size()));
        end
    endtask

endclass

module tb_three_phase_harmonic_synth;

    localparam int RANDOM_ITEMS = 1280;
    localparam int EVAL_CYCLES  = 18 * (tphs_pkg::NUM_HARMONICS_DEF + 1) + 5;
    localparam int DRAIN_CYCLES = EVAL_CYCLES + 40;
    localparam int QUIET_LIMIT  = 4000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_req_valid = 1'b0;
    logic            o_req_stall;
    tphs_pkg::t_req  i_req = '0;
    logic            o_res_valid;
    logic            i_res_stall = 1'b0;
    tphs_pkg::t_res  o_res;

    phase_scoreboard sb = new();
    int              res_hold_cnt = 0;
    int              quiet_cycles = 0;
    int              no_idle_left = 0;

    three_phase_harmonic_synth u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, some medium, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 4);
        end else if (pick < 98) begin
            return $urandom_range(5, 20);
        end
        return $urandom_range(40, 120);
    endfunction

    function automatic logic signed [tphs_pkg::IN_COEF_W-1:0] random_coef();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return tphs_pkg::IN_COEF_W'($urandom);
        endcase
    endfunction

    function automatic tphs_pkg::t_req make_write(int harm, logic [tphs_pkg::SEQ_W-1:0] seq,
                                                  int re, int im);
        tphs_pkg::t_req r;
        r.command      = tphs_pkg::CMD_WRITE;
        r.harmonic     = tphs_pkg::HARM_W'(harm);
        r.sequence_req = seq;
        r.coef_real    = tphs_pkg::IN_COEF_W'(re);
        r.coef_imag    = tphs_pkg::IN_COEF_W'(im);
        r.phase        = tphs_pkg::IN_PHASE_W'($urandom);
        return r;
    endfunction

    function automatic tphs_pkg::t_req make_eval(int angle);
        tphs_pkg::t_req r;
        r.command      = tphs_pkg::CMD_EVAL;
        r.harmonic     = tphs_pkg::HARM_W'($urandom);
        r.sequence_req = tphs_pkg::SEQ_W'($urandom);
        r.coef_real    = tphs_pkg::IN_COEF_W'($urandom);
        r.coef_imag    = tphs_pkg::IN_COEF_W'($urandom);
        r.phase        = tphs_pkg::IN_PHASE_W'(angle);
        return r;
    endfunction

    function automatic tphs_pkg::t_req random_request();
        int pick;
        tphs_pkg::t_req r;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            return make_eval(int'($urandom_range(0, 65535)));
        end
        r = make_write(int'($urandom_range(0, 15)),
                       tphs_pkg::SEQ_W'($urandom_range(0, 2)), 0, 0);
        r.coef_real = random_coef();
        r.coef_imag = random_coef();
        // Keep a few malformed writes with the unused sequence code
        if (pick >= 95) begin
            r.sequence_req = tphs_pkg::SEQ_NONE;
        end
        return r;
    endfunction

    task send_req(tphs_pkg::t_req r);
        int gap;
        gap = (no_idle_left > 0) ? 0 : idle_len();
        if (no_idle_left > 0) begin
            no_idle_left--;
        end
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
    endtask

    // Result-side backpressure in random stretches
    always @(posedge i_clk) begin
        if (res_hold_cnt > 0) begin
            res_hold_cnt <= res_hold_cnt - 1;
        end else begin
            i_res_stall  <= ($urandom_range(0, 2) == 0);
            res_hold_cnt <= idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_req_valid && !o_req_stall) begin
            sb.note_request(i_req);
        end
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            sb.check_result(o_res);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("[three_phase_harmonic_synth] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table, then DC column through the inverse transform
        send_req(make_eval(0));
        send_req(make_write(0, tphs_pkg::SEQ_POS, 32767, -32768));
        send_req(make_write(0, tphs_pkg::SEQ_NEG, -32768, 32767));
        send_req(make_write(0, tphs_pkg::SEQ_ZERO, 32767, 32767));
        send_req(make_eval(0));
        send_req(make_eval(65535));
        // Harmonics 1 and 15: two sequences on 1, each sequence on 15
        send_req(make_write(1, tphs_pkg::SEQ_POS, 32767, 0));
        send_req(make_write(1, tphs_pkg::SEQ_NEG, 0, -32768));
        send_req(make_write(15, tphs_pkg::SEQ_ZERO, -32768, 32767));
        send_req(make_write(15, tphs_pkg::SEQ_POS, 32767, 32767));
        send_req(make_write(15, tphs_pkg::SEQ_NEG, -32768, -32768));
        // Unused sequence code must leave the table alone
        send_req(make_write(7, tphs_pkg::SEQ_NONE, 12345, -23456));
        send_req(make_eval(0));
        send_req(make_eval(16384));
        send_req(make_eval(21845));
        send_req(make_eval(43690));
        send_req(make_eval(65535));
        send_req(make_eval(1));
        send_req(make_write(7, tphs_pkg::SEQ_ZERO, 32767, -32768));
        send_req(make_write(8, tphs_pkg::SEQ_POS, -32768, 32767));
        send_req(make_eval(32768));
        send_req(make_eval(12345));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Open a back-to-back burst now and then
            if (no_idle_left == 0 && $urandom_range(0, 99) == 0) begin
                no_idle_left = $urandom_range(20, 60);
            end
            send_req(random_request());
        end
        i_req_valid <= 1'b0;

        while (sb.expected_phases.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.mismatches == 0) begin
            $display("[three_phase_harmonic_synth] OK");
        end else begin
            $display("[three_phase_harmonic_synth] ERROR");
        end
        $finish;
    end

endmodule

/* three_phase_harmonic_synth.f */
+incdir+rtl
rtl/tphs_pkg.sv
rtl/tphs_table.sv
rtl/tphs_sine_rom.sv
rtl/tphs_mac.sv
rtl/three_phase_harmonic_synth.sv
tb/sv/tb_three_phase_harmonic_synth.sv
